### hdl/snapshot_dedupe_store_unit_assert.svh
// ---------------------------------------------------------------------------
// Snapshot dedupe store assertion macros
// Clocked implication macros for the port checker; they expect clk and rst_n
// in the scope of use.
// ---------------------------------------------------------------------------
`ifndef SNAPSHOT_DEDUPE_STORE_UNIT_ASSERT_SVH
`define SNAPSHOT_DEDUPE_STORE_UNIT_ASSERT_SVH

// same-cycle implication
`define SDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sds_check: property failed");

// next-cycle implication
`define SDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sds_check: property failed");

`endif

### hdl/sds_pkg.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store package
// Command and status codes, key and snapshot records, search token and
// per-entry control.
// ---------------------------------------------------------------------------
package sds_pkg;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam logic [2:0] STATUS_CREATED   = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_CONFLICT  = 3'd2;
    localparam logic [2:0] STATUS_FOUND     = 3'd3;
    localparam logic [2:0] STATUS_NOTFOUND  = 3'd4;
    localparam logic [2:0] STATUS_CLEARED   = 3'd5;

    typedef struct packed {
        logic [31:0] run_id;
        logic [7:0]  marker;
    } key_t;

    typedef struct packed {
        logic [31:0] snap_seq;
        logic [31:0] usb_boundary;
        logic [31:0] spi_frames;
        logic [31:0] accepted_frames;
        logic [31:0] errors_seen;
        logic [15:0] session_number;
        logic [7:0]  alt_setting;
    } snap_t;

    typedef struct packed {
        logic       vld;
        logic [1:0] cmd;
        key_t       key;
        snap_t      snap;
        logic       hit;
        snap_t      hit_snap;
    } tok_t;

    typedef struct packed {
        logic wr_en;
        logic clr;
    } cell_ctl_t;

endpackage

### hdl/sds_if.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store channels
// Valid/ready request and response channels with their item payloads.
// ---------------------------------------------------------------------------
interface sds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] run_id;
    logic [7:0]  marker;
    logic [31:0] snap_seq;
    logic [31:0] usb_boundary;
    logic [31:0] spi_frames;
    logic [31:0] accepted_frames;
    logic [31:0] errors_seen;
    logic [15:0] session_number;
    logic [7:0]  alt_setting;

    modport source (
        output valid, command, run_id, marker, snap_seq, usb_boundary,
               spi_frames, accepted_frames, errors_seen, session_number, alt_setting,
        input  ready
    );
    modport sink (
        input  valid, command, run_id, marker, snap_seq, usb_boundary,
               spi_frames, accepted_frames, errors_seen, session_number, alt_setting,
        output ready
    );
endinterface

interface sds_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_snap_seq;
    logic [31:0] out_usb_boundary;
    logic [31:0] out_spi_frames;
    logic [31:0] out_accepted_frames;
    logic [31:0] out_errors_seen;
    logic [15:0] out_session_number;
    logic [7:0]  out_alt_setting;

    modport source (
        output valid, status, out_snap_seq, out_usb_boundary, out_spi_frames,
               out_accepted_frames, out_errors_seen, out_session_number,
               out_alt_setting,
        input  ready
    );
    modport sink (
        input  valid, status, out_snap_seq, out_usb_boundary, out_spi_frames,
               out_accepted_frames, out_errors_seen, out_session_number,
               out_alt_setting,
        output ready
    );
endinterface

### hdl/snapshot_dedupe_store_unit.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store unit
// An associative store of ENTRIES run snapshots keyed by run id and marker,
// with round-robin replacement. Record answers created, duplicate or
// conflict; find returns the stored snapshot or not found; clear empties the
// store. A request item walks down a row of entry cells, one cell per cycle,
// then waits in a tail register until the response register is free, when
// its response is registered and the next request may be taken; the row
// holds one request at a time. Command code three is dropped with no
// response. No clearing pass follows reset: the valid bits clear at once.
// ---------------------------------------------------------------------------
module snapshot_dedupe_store_unit
    import sds_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    sds_in_if.sink    req,
    sds_out_if.source rsp
);

    localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PEND
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       out_status_reg;
    logic [2:0]       out_status_next;
    snap_t            out_snap_reg;
    snap_t            out_snap_next;
    tok_t             tail_reg;

    tok_t      head_tok;
    tok_t      chain [0:ENTRIES];
    cell_ctl_t cell_ctl [ENTRIES];

    logic       in_fire;
    logic       out_free;
    logic       finish;
    logic       create;
    logic       clr_all;
    logic       same;
    logic       emit;
    logic [2:0] res_status;
    snap_t      res_snap;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;

    always_comb
    begin
        head_tok                      = '0;
        head_tok.vld                  = in_fire;
        head_tok.cmd                  = req.command;
        head_tok.key.run_id           = req.run_id;
        head_tok.key.marker           = req.marker;
        head_tok.snap.snap_seq        = req.snap_seq;
        head_tok.snap.usb_boundary    = req.usb_boundary;
        head_tok.snap.spi_frames      = req.spi_frames;
        head_tok.snap.accepted_frames = req.accepted_frames;
        head_tok.snap.errors_seen     = req.errors_seen;
        head_tok.snap.session_number  = req.session_number;
        head_tok.snap.alt_setting     = req.alt_setting;
    end

    assign chain[0] = head_tok;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        sds_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[g]),
            .ctl     (cell_ctl[g]),
            .wr_key  (tail_reg.key),
            .wr_snap (tail_reg.snap),
            .tok_out (chain[g+1])
        );
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign finish   = (state_reg == S_PEND) && out_free;
    assign same     = (tail_reg.hit_snap == tail_reg.snap);
    assign create   = finish && (tail_reg.cmd == CMD_RECORD) && !tail_reg.hit;
    assign clr_all  = finish && (tail_reg.cmd == CMD_CLEAR);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_ctl[i].wr_en = create && (ptr_reg == PTR_W'(i));
            cell_ctl[i].clr   = clr_all;
        end
    end

    always_comb
    begin
        res_status = STATUS_CLEARED;
        res_snap   = '0;
        emit       = 1'b1;
        unique case (tail_reg.cmd)
            CMD_RECORD:
            begin
                if (tail_reg.hit)
                begin
                    res_status = same ? STATUS_DUPLICATE : STATUS_CONFLICT;
                end
                else
                begin
                    res_status = STATUS_CREATED;
                end
            end
            CMD_FIND:
            begin
                if (tail_reg.hit)
                begin
                    res_status = STATUS_FOUND;
                    res_snap   = tail_reg.hit_snap;
                end
                else
                begin
                    res_status = STATUS_NOTFOUND;
                end
            end
            CMD_CLEAR:
            begin
                res_status = STATUS_CLEARED;
            end
            CMD_RSVD:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_snap_next   = out_snap_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (chain[ENTRIES].vld)
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = res_status;
                        out_snap_next   = res_snap;
                    end
                    if (create)
                    begin
                        ptr_next = (ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
                    end
                    else if (clr_all)
                    begin
                        ptr_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_CREATED;
            out_snap_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_snap_reg   <= out_snap_next;
        end
    end

    // hold the item leaving the row until the response register frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
        end
        else if ((state_reg == S_RUN) && chain[ENTRIES].vld)
        begin
            tail_reg <= chain[ENTRIES];
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = out_status_reg;
    assign rsp.out_snap_seq        = out_snap_reg.snap_seq;
    assign rsp.out_usb_boundary    = out_snap_reg.usb_boundary;
    assign rsp.out_spi_frames      = out_snap_reg.spi_frames;
    assign rsp.out_accepted_frames = out_snap_reg.accepted_frames;
    assign rsp.out_errors_seen     = out_snap_reg.errors_seen;
    assign rsp.out_session_number  = out_snap_reg.session_number;
    assign rsp.out_alt_setting     = out_snap_reg.alt_setting;

endmodule

### hdl/sds_cell.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store entry cell
// Holds one entry, matches the passing search token against it and hands
// the token on to the next cell through a register.
// ---------------------------------------------------------------------------
module sds_cell
    import sds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_t      tok_in,
    input  cell_ctl_t ctl,
    input  key_t      wr_key,
    input  snap_t     wr_snap,
    output tok_t      tok_out
);

    logic  valid_reg;
    logic  valid_next;
    key_t  key_reg;
    snap_t snap_reg;
    logic  tok_vld_reg;
    tok_t  tok_reg;
    tok_t  tok_next;
    logic  match;

    always_comb
    begin
        match    = tok_in.vld && valid_reg && !tok_in.hit && (key_reg == tok_in.key);
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_snap = snap_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.wr_en)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (ctl.wr_en)
        begin
            key_reg  <= wr_key;
            snap_reg <= wr_snap;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = tok_vld_reg;
    end

endmodule

### hdl/sds_check.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store port checker
// Watches the request and response channels of the store and is bound to
// its top level.
// ---------------------------------------------------------------------------
`include "snapshot_dedupe_store_unit_assert.svh"

module sds_check
    import sds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [31:0] out_snap_seq,
    input logic [31:0] out_errors_seen,
    input logic [15:0] out_session_number
);

    logic zero_fields;

    assign zero_fields = (out_snap_seq == 32'd0) && (out_errors_seen == 32'd0) &&
                         (out_session_number == 16'd0);

    `SDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `SDS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(status))
    `SDS_ASSERT_NOW(a_status_range, rsp_valid, status <= STATUS_CLEARED)
    `SDS_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
    `SDS_ASSERT_NOW(a_zero_unless_found, rsp_valid && (status != STATUS_FOUND), zero_fields)

endmodule

bind snapshot_dedupe_store_unit sds_check u_sds_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .status             (rsp.status),
    .out_snap_seq       (rsp.out_snap_seq),
    .out_errors_seen    (rsp.out_errors_seen),
    .out_session_number (rsp.out_session_number)
);

### verif/tb_snapshot_dedupe_store_unit.sv
// ---------------------------------------------------------------------------
// Snapshot dedupe store unit testbench
// Directed and random record, find, clear and reserved-code items go through
// the request channel. A store image kept beside the unit predicts each
// response, and every response is checked field by field in arrival order.
// Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module tb_snapshot_dedupe_store_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sds_pkg::*;

    localparam int ENTRIES        = 8;
    localparam int POOL_SIZE      = 16;
    localparam int SEGMENTS       = 16;
    localparam int SEGMENT_ITEMS  = 100;
    localparam int QUIET_LIMIT    = 4000;

    typedef struct packed {
        logic [2:0] status;
        snap_t      snap;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    sds_in_if  req_if ();
    sds_out_if rsp_if ();

    snapshot_dedupe_store_unit #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    logic [ENTRIES-1:0] slot_valid = '0;
    key_t               slot_key  [ENTRIES];
    snap_t              slot_snap [ENTRIES];
    int                 fill_ptr = 0;
    reply_t             pending_replies [$];
    int                 fail_count = 0;
    bit                 send_idle = 1'b1;
    bit                 recv_idle = 1'b1;
    key_t               key_pool  [POOL_SIZE];
    snap_t              snap_pool [POOL_SIZE];

    function automatic int lookup_slot(key_t k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return ENTRIES;
    endfunction

    function automatic void apply_to_store_image(logic [1:0] cmd, key_t k, snap_t s);
        reply_t r;
        int     hit;
        r   = '0;
        hit = lookup_slot(k);
        case (cmd)
            CMD_RECORD:
            begin
                if (hit < ENTRIES)
                    r.status = (slot_snap[hit] == s) ? STATUS_DUPLICATE : STATUS_CONFLICT;
                else
                begin
                    slot_key[fill_ptr]   = k;
                    slot_snap[fill_ptr]  = s;
                    slot_valid[fill_ptr] = 1'b1;
                    fill_ptr             = (fill_ptr + 1) % ENTRIES;
                    r.status             = STATUS_CREATED;
                end
                pending_replies.push_back(r);
            end
            CMD_FIND:
            begin
                if (hit < ENTRIES)
                begin
                    r.status = STATUS_FOUND;
                    r.snap   = slot_snap[hit];
                end
                else
                    r.status = STATUS_NOTFOUND;
                pending_replies.push_back(r);
            end
            CMD_CLEAR:
            begin
                slot_valid = '0;
                fill_ptr   = 0;
                r.status   = STATUS_CLEARED;
                pending_replies.push_back(r);
            end
            CMD_RSVD:
                ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    function automatic key_t random_key();
        key_t k;
        case ($urandom_range(0, 19))
            0:       k = '0;
            1:       k = '1;
            default: k = {32'($urandom), 8'($urandom)};
        endcase
        return k;
    endfunction

    function automatic snap_t random_snap();
        snap_t s;
        case ($urandom_range(0, 19))
            0:       s = '0;
            1:       s = '1;
            default: s = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                          32'($urandom), 16'($urandom), 8'($urandom)};
        endcase
        return s;
    endfunction

    function automatic snap_t flip_one_field(snap_t s);
        int b;
        b = $urandom_range(0, 31);
        case ($urandom_range(0, 6))
            0: s.snap_seq[b]           = ~s.snap_seq[b];
            1: s.usb_boundary[b]       = ~s.usb_boundary[b];
            2: s.spi_frames[b]         = ~s.spi_frames[b];
            3: s.accepted_frames[b]    = ~s.accepted_frames[b];
            4: s.errors_seen[b]        = ~s.errors_seen[b];
            5: s.session_number[b%16]  = ~s.session_number[b%16];
            6: s.alt_setting[b%8]      = ~s.alt_setting[b%8];
        endcase
        return s;
    endfunction

    task automatic send_item(logic [1:0] cmd, key_t k, snap_t s);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.command         <= cmd;
        req_if.run_id          <= k.run_id;
        req_if.marker          <= k.marker;
        req_if.snap_seq        <= s.snap_seq;
        req_if.usb_boundary    <= s.usb_boundary;
        req_if.spi_frames      <= s.spi_frames;
        req_if.accepted_frames <= s.accepted_frames;
        req_if.errors_seen     <= s.errors_seen;
        req_if.session_number  <= s.session_number;
        req_if.alt_setting     <= s.alt_setting;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_for_replies();
        req_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_and_reserved();
        send_item(CMD_FIND, '0, '0);
        send_item(CMD_RSVD, '0, '1);
        send_item(CMD_CLEAR, '1, '1);
    endtask

    task automatic test_record_outcomes();
        send_item(CMD_RECORD, '0, '0);
        send_item(CMD_RECORD, '0, '0);
        send_item(CMD_RECORD, '0, '1);
        send_item(CMD_FIND, '0, '1);
        send_item(CMD_RECORD, '1, '1);
        send_item(CMD_FIND, '1, '0);
        send_item(CMD_FIND, {32'hFFFF_FFFF, 8'h00}, '0);
        send_item(CMD_RSVD, '0, '1);
        send_item(CMD_FIND, '0, '0);
    endtask

    task automatic test_replacement_order();
        for (int i = 2; i < ENTRIES; i++)
            send_item(CMD_RECORD, {32'(i), 8'h5A}, random_snap());
        send_item(CMD_RECORD, {32'(ENTRIES), 8'h5A}, random_snap());
        send_item(CMD_FIND, '0, '0);
        send_item(CMD_RECORD, '0, '0);
        send_item(CMD_FIND, '1, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_FIND, {32'(ENTRIES), 8'h5A}, '0);
        send_item(CMD_RECORD, {32'(ENTRIES), 8'h5A}, '1);
        wait_for_replies();
    endtask

    task automatic send_random_item(output bit counted);
        logic [1:0] cmd;
        key_t       k;
        snap_t      s;
        int         idx;
        int         pick;
        idx  = $urandom_range(0, POOL_SIZE - 1);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            cmd = CMD_RECORD;
        else if (pick < 88)
            cmd = CMD_FIND;
        else if (pick < 93)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_RSVD;
        if ($urandom_range(0, 49) == 0)
        begin
            key_pool[idx]  = random_key();
            snap_pool[idx] = random_snap();
        end
        k    = key_pool[idx];
        pick = $urandom_range(0, 99);
        if (pick < 10)
            k = random_key();
        else if (pick < 18)
            k.marker = 8'($urandom);
        s    = snap_pool[idx];
        pick = $urandom_range(0, 99);
        if (pick < 25)
            s = flip_one_field(s);
        else if (pick < 40)
            s = random_snap();
        send_item(cmd, k, s);
        counted = (cmd != CMD_RSVD);
    endtask

    task automatic test_random_traffic();
        int sent;
        bit counted;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i]  = random_key();
            snap_pool[i] = random_snap();
        end
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg >= SEGMENTS - 2)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            else
            begin
                send_idle = $urandom_range(0, 3) != 0;
                recv_idle = $urandom_range(0, 3) != 0;
            end
            sent = 0;
            while (sent < SEGMENT_ITEMS)
            begin
                send_random_item(counted);
                if (counted)
                    sent++;
            end
            if ((seg % 4 == 3) && (seg < SEGMENTS - 2))
                wait_for_replies();
        end
    endtask

    initial
    begin
        reply_t want;
        int     stall_left;
        int     quiet_cycles;
        stall_left   = 0;
        quiet_cycles = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (req_if.valid && req_if.ready)
                    apply_to_store_image(req_if.command, {req_if.run_id, req_if.marker},
                        {req_if.snap_seq, req_if.usb_boundary, req_if.spi_frames,
                         req_if.accepted_frames, req_if.errors_seen,
                         req_if.session_number, req_if.alt_setting});
                if (rsp_if.valid && rsp_if.ready)
                begin
                    if (pending_replies.size() == 0)
                    begin
                        $error("unexpected response item, status %0d", rsp_if.status);
                        fail_count++;
                    end
                    else
                    begin
                        want = pending_replies.pop_front();
                        check_field("status", want.status, rsp_if.status);
                        check_field("out_snap_seq", want.snap.snap_seq,
                                    rsp_if.out_snap_seq);
                        check_field("out_usb_boundary", want.snap.usb_boundary,
                                    rsp_if.out_usb_boundary);
                        check_field("out_spi_frames", want.snap.spi_frames,
                                    rsp_if.out_spi_frames);
                        check_field("out_accepted_frames", want.snap.accepted_frames,
                                    rsp_if.out_accepted_frames);
                        check_field("out_errors_seen", want.snap.errors_seen,
                                    rsp_if.out_errors_seen);
                        check_field("out_session_number", want.snap.session_number,
                                    rsp_if.out_session_number);
                        check_field("out_alt_setting", want.snap.alt_setting,
                                    rsp_if.out_alt_setting);
                    end
                end
                if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("RESULT: ERROR");
                    $finish;
                end
                else if (recv_idle && stall_left > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    stall_left--;
                end
                else if (recv_idle && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 10) - 1;
                    rsp_if.ready <= 1'b0;
                end
                else
                    rsp_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.command         = CMD_RECORD;
        req_if.run_id          = '0;
        req_if.marker          = '0;
        req_if.snap_seq        = '0;
        req_if.usb_boundary    = '0;
        req_if.spi_frames      = '0;
        req_if.accepted_frames = '0;
        req_if.errors_seen     = '0;
        req_if.session_number  = '0;
        req_if.alt_setting     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_reserved();
        test_record_outcomes();
        test_replacement_order();
        test_random_traffic();

        wait_for_replies();
        repeat (2 * ENTRIES + 4) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/sds_pkg.sv
hdl/sds_if.sv
hdl/sds_cell.sv
hdl/snapshot_dedupe_store_unit.sv
hdl/sds_check.sv
verif/tb_snapshot_dedupe_store_unit.sv
